>>> rtl/ams_pkg.sv
package ams_pkg;

    localparam int NOTE_COUNT     = 8;
    localparam int STROBE_HALF_MS = 40;
    localparam int STROBE_CYCLE   = 2 * STROBE_HALF_MS;
    localparam int STROBE_W       = $clog2(STROBE_CYCLE);
    localparam int IDX_W          = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int MS_W           = 16;
    localparam int NOTE_LEN_MAX   = 255;
    localparam int STROBE_STEPS   = (NOTE_LEN_MAX + STROBE_CYCLE - 1) / STROBE_CYCLE;
    localparam int PADDR_W        = 3;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic REG_BUZZER_PRESENT = 1'b0;
    localparam logic REG_SPEAKER_READY  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_NOTE  = 2'd1,
        PH_PAUSE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RT_BUZZER  = 2'd0,
        RT_SPEAKER = 2'd1,
        RT_LEDS    = 2'd2
    } t_route;

    typedef struct packed {
        logic            kind;
        logic [MS_W-1:0] alarm_duration_ms;
    } t_in_item;

    typedef struct packed {
        logic [9:0] tone_freq;
        logic [1:0] route;
        logic       led_on;
        logic       playing;
        logic       finished;
        logic       speaker_power_down;
    } t_out_item;

    typedef struct packed {
        logic [9:0] freq;
        logic [7:0] len;
        logic [7:0] pause;
    } t_note;

    function automatic t_note melody_note(input logic [2:0] idx);
        t_note n;
        case (idx)
            3'd0: n = '{freq: 10'd466, len: 8'd150, pause: 8'd25};
            3'd1: n = '{freq: 10'd622, len: 8'd170, pause: 8'd25};
            3'd2: n = '{freq: 10'd440, len: 8'd150, pause: 8'd25};
            3'd3: n = '{freq: 10'd587, len: 8'd160, pause: 8'd25};
            3'd4: n = '{freq: 10'd311, len: 8'd230, pause: 8'd35};
            3'd5: n = '{freq: 10'd880, len: 8'd140, pause: 8'd20};
            3'd6: n = '{freq: 10'd622, len: 8'd180, pause: 8'd30};
            3'd7: n = '{freq: 10'd370, len: 8'd210, pause: 8'd40};
            default: n = '{freq: 10'd0, len: 8'd0, pause: 8'd0};
        endcase
        return n;
    endfunction

endpackage

>>> rtl/alarm_melody_sequencer.sv
// Latency: a result item is presented in the cycle after its input item is accepted.
// Throughput: one item per cycle; the whole step runs between the state registers
// and the result register, and the input is stalled only while a held result is stalled.
// Reset (synchronous, active low) returns the sequencer to idle with the buzzer
// route, clears both configuration registers and empties the result register.
module alarm_melody_sequencer
    import ams_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef struct packed {
        t_phase          phase;
        logic [MS_W-1:0] len;
        logic            ended;
        logic            skip;
    } t_step;

    logic                r_buzzer;
    logic                r_speaker;
    t_phase              r_phase,     n_phase;
    t_route              r_route,     n_route;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic [MS_W-1:0]     r_elapsed,   n_elapsed;
    logic [MS_W-1:0]     r_total,     n_total;
    logic [MS_W-1:0]     r_phase_ms,  n_phase_ms;
    logic [MS_W-1:0]     r_phase_len, n_phase_len;
    logic [STROBE_W-1:0] r_strobe,    n_strobe;
    logic                r_out_valid;
    t_out_item           r_out,       n_out;

    logic  in_fire;
    logic  load;
    logic  pulse;
    t_step st;
    t_step pz;
    t_note cur;

    function automatic logic [2:0] rom_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] ext;
        ext = (IDX_W + 3)'(idx);
        return ext[2:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(NOTE_COUNT - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [MS_W-1:0] strobe_round(input logic [7:0] len);
        logic [MS_W-1:0] res;
        res = '0;
        for (int k = STROBE_STEPS; k >= 1; k--) begin
            if (MS_W'(len) <= MS_W'(k * STROBE_CYCLE)) begin
                res = MS_W'(k * STROBE_CYCLE);
            end
        end
        return res;
    endfunction

    function automatic t_step begin_note(input logic [MS_W-1:0] elapsed,
                                         input logic [MS_W-1:0] total,
                                         input logic [IDX_W-1:0] idx,
                                         input logic leds);
        t_step           s;
        t_note           nt;
        logic [MS_W-1:0] rem;
        logic [7:0]      len;
        nt  = melody_note(rom_idx(idx));
        rem = total - elapsed;
        len = (MS_W'(nt.len) > rem) ? rem[7:0] : nt.len;
        s   = '{phase: PH_NOTE, len: MS_W'(len), ended: 1'b0, skip: 1'b0};
        if (elapsed >= total || len == 8'd0) begin
            s = '{phase: PH_IDLE, len: '0, ended: 1'b1, skip: 1'b0};
        end else if (leds) begin
            s.len = strobe_round(len);
        end
        return s;
    endfunction

    function automatic t_step begin_pause(input logic [MS_W-1:0] elapsed,
                                          input logic [MS_W-1:0] total,
                                          input logic [IDX_W-1:0] idx);
        t_step           s;
        t_note           nt;
        logic [MS_W-1:0] rem;
        logic [7:0]      len;
        nt  = melody_note(rom_idx(idx));
        rem = total - elapsed;
        len = (MS_W'(nt.pause) > rem) ? rem[7:0] : nt.pause;
        s   = '{phase: PH_PAUSE, len: MS_W'(len), ended: 1'b0, skip: 1'b0};
        if (elapsed >= total) begin
            s = '{phase: PH_IDLE, len: '0, ended: 1'b1, skip: 1'b0};
        end else if (len == 8'd0) begin
            s.skip = 1'b1;
        end
        return s;
    endfunction

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_fire     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_BUZZER_PRESENT: prdata = {31'd0, r_buzzer};
            REG_SPEAKER_READY:  prdata = {31'd0, r_speaker};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buzzer  <= 1'b0;
            r_speaker <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_BUZZER_PRESENT: r_buzzer  <= pwdata[0];
                REG_SPEAKER_READY:  r_speaker <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_route     = r_route;
        n_idx       = r_idx;
        n_elapsed   = r_elapsed;
        n_total     = r_total;
        n_phase_ms  = r_phase_ms;
        n_phase_len = r_phase_len;
        n_strobe    = r_strobe;
        load        = 1'b0;
        pulse       = 1'b0;
        st          = '{phase: PH_IDLE, len: '0, ended: 1'b0, skip: 1'b0};
        pz          = '{phase: PH_IDLE, len: '0, ended: 1'b0, skip: 1'b0};
        if (in_fire) begin
            if (i_in_item.kind == KIND_START) begin
                if (r_phase == PH_IDLE) begin
                    n_route   = r_buzzer ? RT_BUZZER : (r_speaker ? RT_SPEAKER : RT_LEDS);
                    n_total   = i_in_item.alarm_duration_ms;
                    n_elapsed = '0;
                    n_idx     = '0;
                    st        = begin_note('0, i_in_item.alarm_duration_ms, '0,
                                           n_route == RT_LEDS);
                    load      = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                n_elapsed  = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
                n_phase_ms = r_phase_ms + 1'b1;
                if (r_phase == PH_NOTE) begin
                    n_strobe = (r_strobe == STROBE_W'(STROBE_CYCLE - 1)) ? '0
                                                                           : r_strobe + 1'b1;
                end
                if (n_phase_ms >= r_phase_len) begin
                    load = 1'b1;
                    if (r_phase == PH_NOTE) begin
                        pz = begin_pause(n_elapsed, r_total, r_idx);
                        if (pz.skip) begin
                            n_idx = idx_inc(r_idx);
                            st    = begin_note(n_elapsed, r_total, n_idx, r_route == RT_LEDS);
                        end else begin
                            st = pz;
                        end
                    end else begin
                        n_idx = idx_inc(r_idx);
                        st    = begin_note(n_elapsed, r_total, n_idx, r_route == RT_LEDS);
                    end
                end
            end
        end
        if (load) begin
            n_phase     = st.phase;
            n_phase_ms  = '0;
            n_phase_len = st.len;
            n_strobe    = '0;
            pulse       = st.ended;
        end
    end

    always_comb begin
        cur                      = melody_note(rom_idx(n_idx));
        n_out.tone_freq          = '0;
        n_out.route              = n_route;
        n_out.led_on             = 1'b0;
        n_out.playing            = (n_phase != PH_IDLE);
        n_out.finished           = pulse;
        n_out.speaker_power_down = pulse && (n_route == RT_SPEAKER);
        if (n_phase == PH_NOTE) begin
            if (n_route == RT_LEDS) begin
                n_out.led_on = (n_strobe < STROBE_W'(STROBE_HALF_MS));
            end else begin
                n_out.led_on    = 1'b1;
                n_out.tone_freq = cur.freq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_route     <= RT_BUZZER;
            r_idx       <= '0;
            r_elapsed   <= '0;
            r_total     <= '0;
            r_phase_ms  <= '0;
            r_phase_len <= '0;
            r_strobe    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_route     <= n_route;
            r_idx       <= n_idx;
            r_elapsed   <= n_elapsed;
            r_total     <= n_total;
            r_phase_ms  <= n_phase_ms;
            r_phase_len <= n_phase_len;
            r_strobe    <= n_strobe;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/ams_checker.sv
module ams_checker
    import ams_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |-> !o_out_item.playing)
        else $error("finished item still shows playing");

    a_power_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.speaker_power_down |->
            o_out_item.finished && o_out_item.route == RT_SPEAKER)
        else $error("speaker power-down outside a speaker finish");

    a_silent_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.playing |->
            o_out_item.tone_freq == 10'd0 && !o_out_item.led_on)
        else $error("tone or LED active while not playing");

    a_leds_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.route == RT_LEDS |-> o_out_item.tone_freq == 10'd0)
        else $error("tone given on the LED-only route");

endmodule

bind alarm_melody_sequencer ams_checker u_ams_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ams_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS = 220;
    localparam int SHOW_MAX    = 50;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    alarm_melody_sequencer dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Melody table: tone in Hz, note length and following pause in ms.
    int melody_hz  [8] = '{466, 622, 440, 587, 311, 880, 622, 370};
    int melody_len [8] = '{150, 170, 150, 160, 230, 140, 180, 210};
    int melody_gap [8] = '{25, 25, 25, 25, 35, 20, 30, 40};

    bit     cfg_buzzer;
    bit     cfg_speaker;
    t_phase alarm_phase = PH_IDLE;
    t_route alarm_route = RT_BUZZER;
    int     note_idx;
    int     elapsed_ms;
    int     total_ms;
    int     phase_ms;
    int     phase_len;
    int     strobe_ms;
    bit     end_pulse;

    t_in_item  pending_items[$];
    t_out_item due_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatches;
    int        cycle_count;
    int        queued;
    bit        item_taken;

    function automatic int rom_slot();
        return (note_idx % NOTE_COUNT) & 7;
    endfunction

    function automatic void finish_alarm();
        alarm_phase = PH_IDLE;
        phase_ms    = 0;
        phase_len   = 0;
        strobe_ms   = 0;
        end_pulse   = 1'b1;
    endfunction

    function automatic void start_note();
        int len;
        if (elapsed_ms >= total_ms) begin
            finish_alarm();
            return;
        end
        len = melody_len[rom_slot()];
        if (len > total_ms - elapsed_ms) len = total_ms - elapsed_ms;
        if (len == 0) begin
            finish_alarm();
            return;
        end
        // In LED-only mode the strobe always completes whole on/off cycles.
        if (alarm_route == RT_LEDS) begin
            len = ((len + STROBE_CYCLE - 1) / STROBE_CYCLE) * STROBE_CYCLE;
        end
        alarm_phase = PH_NOTE;
        phase_ms    = 0;
        phase_len   = len;
        strobe_ms   = 0;
    endfunction

    function automatic void start_pause();
        int len;
        if (elapsed_ms >= total_ms) begin
            finish_alarm();
            return;
        end
        len = melody_gap[rom_slot()];
        if (len > total_ms - elapsed_ms) len = total_ms - elapsed_ms;
        if (len == 0) begin
            note_idx = (note_idx + 1) % NOTE_COUNT;
            start_note();
            return;
        end
        alarm_phase = PH_PAUSE;
        phase_ms    = 0;
        phase_len   = len;
        strobe_ms   = 0;
    endfunction

    function automatic void count_ms();
        if (elapsed_ms < 65535) elapsed_ms++;
        phase_ms++;
        if (alarm_phase == PH_NOTE) begin
            strobe_ms++;
            if (strobe_ms >= STROBE_CYCLE) strobe_ms = 0;
        end
        if (phase_ms < phase_len) return;
        if (alarm_phase == PH_NOTE) begin
            start_pause();
        end else begin
            note_idx = (note_idx + 1) % NOTE_COUNT;
            start_note();
        end
    endfunction

    function automatic t_out_item melody_step(input t_in_item it);
        t_out_item res;
        end_pulse = 1'b0;
        if (it.kind == KIND_START) begin
            if (alarm_phase == PH_IDLE) begin
                if (cfg_buzzer) alarm_route = RT_BUZZER;
                else if (cfg_speaker) alarm_route = RT_SPEAKER;
                else alarm_route = RT_LEDS;
                total_ms   = it.alarm_duration_ms;
                elapsed_ms = 0;
                note_idx   = 0;
                start_note();
            end
        end else if (alarm_phase != PH_IDLE) begin
            count_ms();
        end
        res = '0;
        if (alarm_phase == PH_NOTE) begin
            if (alarm_route == RT_LEDS) begin
                res.led_on = (strobe_ms < STROBE_HALF_MS);
            end else begin
                res.led_on    = 1'b1;
                res.tone_freq = 10'(melody_hz[rom_slot()]);
            end
        end
        res.route              = alarm_route;
        res.playing            = (alarm_phase != PH_IDLE);
        res.finished           = end_pulse;
        res.speaker_power_down = end_pulse && (alarm_route == RT_SPEAKER);
        end_pulse = 1'b0;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (mismatches < SHOW_MAX) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL alarm_melody_sequencer");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            item_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result item with nothing pending", o_out_item, 16'd0);
                end else begin
                    want = due_results.pop_front();
                    check_field("tone_freq", 16'(o_out_item.tone_freq), 16'(want.tone_freq));
                    check_field("route", 16'(o_out_item.route), 16'(want.route));
                    check_field("led_on", 16'(o_out_item.led_on), 16'(want.led_on));
                    check_field("playing", 16'(o_out_item.playing), 16'(want.playing));
                    check_field("finished", 16'(o_out_item.finished), 16'(want.finished));
                    check_field("speaker_power_down", 16'(o_out_item.speaker_power_down),
                                16'(want.speaker_power_down));
                end
            end
            if (i_in_valid && !o_in_stall) due_results.push_back(melody_step(i_in_item));
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || item_taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_routing(input bit buzzer, input bit speaker);
        reg_write({REG_BUZZER_PRESENT, 2'b00}, {31'd0, buzzer});
        reg_write({REG_SPEAKER_READY, 2'b00}, {31'd0, speaker});
        cfg_buzzer  = buzzer;
        cfg_speaker = speaker;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || i_in_valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic void push_item(input logic kind, input int dur);
        t_in_item it;
        it.kind              = kind;
        it.alarm_duration_ms = dur[15:0];
        pending_items.push_back(it);
        queued++;
    endfunction

    function automatic void push_tick();
        push_item(KIND_TICK, $urandom_range(65535));
    endfunction

    // One alarm: a start, ticks for the run plus a random margin of up to two strobe
    // periods, stray starts while it plays and, now and then, a run cut short.
    function automatic void queue_alarm(input int dur, input bit may_break);
        int ticks;
        ticks = dur + $urandom_range(0, 2 * STROBE_CYCLE);
        if (may_break && $urandom_range(9) == 0) ticks = $urandom_range(0, ticks);
        push_item(KIND_START, dur);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(49) == 0) push_item(KIND_START, $urandom_range(65535));
            push_tick();
        end
        repeat ($urandom_range(0, 3)) push_tick();
    endfunction

    function automatic int pick_duration();
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom_range(1, 12);
            2, 3, 4: return $urandom_range(13, 250);
            5, 6: return $urandom_range(251, 450);
            default: return $urandom_range(451, 700);
        endcase
    endfunction

    initial begin
        int seq_no;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_routing(1'b1, 1'b0);
        push_item(KIND_TICK, 16'hFFFF);
        push_item(KIND_START, 0);
        push_item(KIND_START, 2);
        push_item(KIND_START, 16'hFFFF);
        push_item(KIND_TICK, 0);
        push_item(KIND_TICK, 0);
        push_item(KIND_TICK, 16'hFFFF);
        drain();
        set_routing(1'b0, 1'b1);
        push_item(KIND_START, 0);
        push_item(KIND_START, 1);
        push_item(KIND_TICK, 16'h5555);
        drain();
        set_routing(1'b1, 1'b1);
        push_item(KIND_START, 0);
        push_item(KIND_TICK, 16'hAAAA);
        drain();
        set_routing(1'b0, 1'b0);
        push_item(KIND_START, 0);
        push_item(KIND_START, 1);
        repeat (STROBE_CYCLE) push_tick();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            queued = 0;
            seq_no = $urandom_range(3);
            while (queued < PHASE_ITEMS) begin
                set_routing(seq_no[1], seq_no[0]);
                queue_alarm(pick_duration(), 1'b1);
                drain();
                seq_no++;
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS alarm_melody_sequencer");
        end else begin
            $display("FAIL alarm_melody_sequencer");
        end
        $finish;
    end

endmodule
